// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SVN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svn assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SVN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svn assertion failed");

`endif

// ----- rtl/svn_pkg.sv -----
// Shared widths, hash constants and register codes for the smoothed value noise unit.
`timescale 1ns / 1ps

package svn_pkg;

  localparam int ROW_W        = 6;
  localparam int COL_W        = 6;
  localparam int OUT_W        = 36;
  localparam int WORD_W       = 32;
  localparam int MAP_SIZE_DEF = 64;
  localparam int PIPE_DEPTH   = 7;
  localparam int LANES        = 9;

  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  // paddr bit that selects the 32-bit register word
  localparam int CFG_IDX_BIT  = 2;

  // register word index
  localparam logic [0:0] REG_SEED = 1'b0;

  // lattice hash constants
  localparam logic [WORD_W-1:0] Y_MUL    = 32'd57;
  localparam logic [WORD_W-1:0] SEED_MUL = 32'd131;
  localparam int                SHIFT    = 13;
  localparam logic [WORD_W-1:0] K_MUL    = 32'd15731;
  localparam logic [WORD_W-1:0] K_ADD    = 32'd789221;
  localparam logic [WORD_W-1:0] K_OFS    = 32'd1376312589;
  localparam logic [WORD_W-1:0] LVL_MASK = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] LVL_TOP  = 32'h8000_0000;

endpackage

// ----- rtl/svn_if.sv -----
// Valid/ready channel interfaces for map positions and smoothed results.
`timescale 1ns / 1ps

interface svn_in_if;
  logic                       valid;
  logic                       ready;
  logic [svn_pkg::ROW_W-1:0]  row;
  logic [svn_pkg::COL_W-1:0]  col;

  modport source (output valid, output row, output col, input ready);
  modport sink   (input valid, input row, input col, output ready);
endinterface

interface svn_out_if;
  logic                       valid;
  logic                       ready;
  logic [svn_pkg::OUT_W-1:0]  smoothed_value;

  modport source (output valid, output smoothed_value, input ready);
  modport sink   (input valid, input smoothed_value, output ready);
endinterface

// ----- rtl/smoothed_value_noise_unit.sv -----
// Smoothed value noise unit: 3x3 weighted integer-hash noise, seven-stage pipeline.
`timescale 1ns / 1ps

// Takes one map position (row, col) per item and returns the smoothed noise
// level at that spot on a MAP_SIZE x MAP_SIZE torus, in units of 2^-27 (real
// range 0 to 256). Nine hash lanes evaluate the 3x3 neighborhood side by side;
// the center weighs 4, the side neighbors 2 and the corners 1. Throughput is
// one item per clock while the output is not stalled. The seven register
// stages are the coordinate mix, the hash chain in each lane (square, scale,
// second 32x32 multiply, level) and the two-level weighted adder tree. Each
// stage has its own valid bit and load enable, so a stall at the output only
// backs up full stages and bubbles keep filling. The seed register sits at
// byte address 0 of the APB port, resets to zero and reads back; write it
// only while no item is in flight. There is no memory and no clearing pass
// after reset.
module smoothed_value_noise_unit #(
  parameter int MAP_SIZE = svn_pkg::MAP_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  svn_in_if.sink                          in_ch,
  svn_out_if.source                       out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [svn_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [svn_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [svn_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  localparam int R_W     = $clog2(MAP_SIZE);
  localparam int CRD_W   = $clog2(MAP_SIZE + 1);
  localparam int IN_SPAN = 2 ** svn_pkg::ROW_W;
  localparam int ND      = svn_pkg::PIPE_DEPTH;
  localparam int LN      = svn_pkg::LANES;
  localparam int W       = svn_pkg::WORD_W;
  localparam int OW      = svn_pkg::OUT_W;

  // ---------------------------------------------------------------------------
  // Configuration: seed, with seed*131 kept alongside so stage 1 only adds.
  // ---------------------------------------------------------------------------
  logic         cfg_wr;
  logic [W-1:0] seed_r;
  logic [W-1:0] seed131_r;

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r    <= '0;
      seed131_r <= '0;
    end else if (cfg_wr && (cfg_paddr[svn_pkg::CFG_IDX_BIT] == svn_pkg::REG_SEED)) begin
      seed_r    <= cfg_pwdata;
      seed131_r <= cfg_pwdata * svn_pkg::SEED_MUL;
    end
  end

  assign cfg_prdata = (cfg_paddr[svn_pkg::CFG_IDX_BIT] == svn_pkg::REG_SEED) ? seed_r : '0;
  assign cfg_pready = 1'b1;

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or the one after loads.
  // ---------------------------------------------------------------------------
  logic [ND:1]   v_r;
  logic [ND:1]   v_nxt;
  logic [ND:1]   v_src;
  logic [ND+1:1] ld;

  always_comb begin
    ld[ND+1] = out_ch.ready;
    for (int k = ND; k >= 1; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
    v_src = {v_r[ND-1:1], in_ch.valid};
    for (int k = 1; k <= ND; k++) begin
      v_nxt[k] = ld[k] ? v_src[k] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready         = ld[1];
  assign out_ch.valid        = v_r[ND];

  // ---------------------------------------------------------------------------
  // Stage 1: reduce position onto the torus, form neighbor coordinates, mix.
  // ---------------------------------------------------------------------------
  // position mod MAP_SIZE, resolved at elaboration
  logic [R_W-1:0] mod_tab [IN_SPAN];

  for (genvar g = 0; g < IN_SPAN; g++) begin : g_mod
    assign mod_tab[g] = R_W'(g % MAP_SIZE);
  end

  logic [R_W-1:0]   r_idx;
  logic [R_W-1:0]   c_idx;
  logic [CRD_W-1:0] xs [3];
  logic [CRD_W-1:0] ys [3];
  logic [W-1:0]     base [LN];
  logic [W-1:0]     n_nxt [LN];

  always_comb begin
    r_idx = mod_tab[in_ch.row];
    c_idx = mod_tab[in_ch.col];
    // hash coordinate is the wrapped neighbor index plus one
    xs[0] = (r_idx == '0) ? CRD_W'(MAP_SIZE) : CRD_W'(r_idx);
    xs[1] = CRD_W'(r_idx) + CRD_W'(1);
    xs[2] = (r_idx == R_W'(MAP_SIZE - 1)) ? CRD_W'(1) : CRD_W'(r_idx) + CRD_W'(2);
    ys[0] = (c_idx == '0) ? CRD_W'(MAP_SIZE) : CRD_W'(c_idx);
    ys[1] = CRD_W'(c_idx) + CRD_W'(1);
    ys[2] = (c_idx == R_W'(MAP_SIZE - 1)) ? CRD_W'(1) : CRD_W'(c_idx) + CRD_W'(2);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        base[3*i+j]  = W'(xs[i]) + W'(ys[j]) * svn_pkg::Y_MUL + seed131_r;
        n_nxt[3*i+j] = (base[3*i+j] << svn_pkg::SHIFT) ^ base[3*i+j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2-5: per-lane hash, all arithmetic wraps at 32 bits.
  // ---------------------------------------------------------------------------
  logic [W-1:0] s1_n_r   [LN];
  logic [W-1:0] s2_n_r   [LN];
  logic [W-1:0] s2_sq_r  [LN];
  logic [W-1:0] s3_n_r   [LN];
  logic [W-1:0] s3_t_r   [LN];
  logic [W-1:0] s4_h_r   [LN];
  logic [W-1:0] s5_lvl_r [LN];

  logic [W-1:0] sq_nxt  [LN];
  logic [W-1:0] t_nxt   [LN];
  logic [W-1:0] h_nxt   [LN];
  logic [W-1:0] hs      [LN];
  logic [W-1:0] lvl_nxt [LN];

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      sq_nxt[l]  = s1_n_r[l] * s1_n_r[l];
      t_nxt[l]   = s2_sq_r[l] * svn_pkg::K_MUL + svn_pkg::K_ADD;
      h_nxt[l]   = s3_n_r[l] * s3_t_r[l];
      hs[l]      = s4_h_r[l] + svn_pkg::K_OFS;
      // level runs 1 .. 2^31, still fits 32 bits
      lvl_nxt[l] = svn_pkg::LVL_TOP - (hs[l] & svn_pkg::LVL_MASK);
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 6-7: weighted sum, row partials then total.
  // ---------------------------------------------------------------------------
  logic [OW-1:0] s6_part_r [3];
  logic [OW-1:0] s7_sum_r;
  logic [OW-1:0] part_nxt  [3];
  logic [OW-1:0] sum_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (i == 1) begin
        // middle row: sides 2, center 4
        part_nxt[i] = (OW'(s5_lvl_r[3*i]) << 1) + (OW'(s5_lvl_r[3*i+1]) << 2)
                    + (OW'(s5_lvl_r[3*i+2]) << 1);
      end else begin
        // outer rows: corners 1, side 2
        part_nxt[i] = OW'(s5_lvl_r[3*i]) + (OW'(s5_lvl_r[3*i+1]) << 1)
                    + OW'(s5_lvl_r[3*i+2]);
      end
    end
    sum_nxt = s6_part_r[0] + s6_part_r[1] + s6_part_r[2];
  end

  // payload registers, no reset; each stage loads on its own enable
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_n_r <= n_nxt;
    end
    if (ld[2]) begin
      s2_n_r  <= s1_n_r;
      s2_sq_r <= sq_nxt;
    end
    if (ld[3]) begin
      s3_n_r <= s2_n_r;
      s3_t_r <= t_nxt;
    end
    if (ld[4]) begin
      s4_h_r <= h_nxt;
    end
    if (ld[5]) begin
      s5_lvl_r <= lvl_nxt;
    end
    if (ld[6]) begin
      s6_part_r <= part_nxt;
    end
    if (ld[7]) begin
      s7_sum_r <= sum_nxt;
    end
  end

  assign out_ch.smoothed_value = s7_sum_r;

endmodule

// ----- rtl/svn_checker.sv -----
// Port-level checker for the smoothed value noise unit, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module svn_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            cfg_psel,
  input logic                            cfg_penable,
  input logic                            cfg_pwrite,
  input logic                            cfg_pready,
  input logic [svn_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input logic [svn_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  input logic [svn_pkg::CFG_DATA_W-1:0]  cfg_prdata
);

  localparam int CNT_W = $clog2(svn_pkg::PIPE_DEPTH + 2);

  logic             in_acc;
  logic             out_acc;
  logic             cfg_wr;
  logic             seed_sel;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign seed_sel = (cfg_paddr[svn_pkg::CFG_IDX_BIT] == svn_pkg::REG_SEED);

  // items accepted but not yet delivered
  always_comb begin
    cnt_nxt = cnt_r + CNT_W'(in_acc) - CNT_W'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `SVN_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `SVN_ASSERT_IMP(a_no_phantom, out_valid, cnt_r != '0)
  `SVN_ASSERT_IMP(a_capacity, 1'b1, cnt_r <= CNT_W'(svn_pkg::PIPE_DEPTH))
  `SVN_ASSERT_NXT(a_seed_rb, cfg_wr && seed_sel, !seed_sel || cfg_prdata == $past(cfg_pwdata))

endmodule

bind smoothed_value_noise_unit svn_checker u_svn_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_pready  (cfg_pready),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata)
);

// ----- sim/testbench.sv -----
// Self-checking testbench for the smoothed value noise unit.
`timescale 1ns / 1ps

module testbench;

  localparam int GRID        = 64;
  localparam int CLK_HALF    = 10;
  localparam int IDLE_PCT    = 19;
  localparam int PHASE_ITEMS = 229;
  localparam int HOLD_CYCLES = 64;

  // byte address of the seed word on the config port
  localparam logic [svn_pkg::CFG_ADDR_W-1:0] SEED_ADDR =
    svn_pkg::CFG_ADDR_W'(svn_pkg::REG_SEED) << svn_pkg::CFG_IDX_BIT;

  // our own copy of the lattice hash constants
  localparam logic [31:0] HASH_Y   = 32'd57;
  localparam logic [31:0] HASH_S   = 32'd131;
  localparam logic [31:0] HASH_K1  = 32'd15731;
  localparam logic [31:0] HASH_K2  = 32'd789221;
  localparam logic [31:0] HASH_K3  = 32'd1376312589;
  localparam logic [31:0] LOW_MASK = 32'h7fff_ffff;
  localparam logic [35:0] LVL_FULL = 36'h0_8000_0000;

  typedef struct packed {
    logic [svn_pkg::ROW_W-1:0] row;
    logic [svn_pkg::COL_W-1:0] col;
  } position_t;

  logic clk;
  logic rst_n;

  svn_in_if  in_ch ();
  svn_out_if out_ch ();

  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [svn_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [svn_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [svn_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  smoothed_value_noise_unit #(
    .MAP_SIZE (GRID)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Expected smoothed levels, oldest first, plus the seed the block holds now.
  logic [svn_pkg::OUT_W-1:0] expected_levels[$];
  logic [31:0]               seed_now;

  int  mismatches;
  int  items_sent;
  int  levels_checked;
  int  seeds_used;
  bit  steady;          // no idling on either side while set
  int  stall_requests;  // bumped by the stimulus to ask for a long receiver hold

  // ---------------------------------------------------------------------------
  // Predictor: hash one lattice point and weight the 3x3 neighborhood.
  // ---------------------------------------------------------------------------
  function automatic logic [35:0] lattice_level(input logic [31:0] x, input logic [31:0] y,
                                                input logic [31:0] sd);
    logic [31:0] n;
    logic [31:0] h;
    n = x + y * HASH_Y + sd * HASH_S;
    n = (n << 13) ^ n;
    h = n * (n * n * HASH_K1 + HASH_K2) + HASH_K3;
    return LVL_FULL - {4'd0, h & LOW_MASK};
  endfunction

  function automatic logic [svn_pkg::OUT_W-1:0] smoothed_level(input position_t pos,
                                                               input logic [31:0] sd);
    logic [31:0] r;
    logic [31:0] c;
    logic [31:0] xs[3];
    logic [31:0] ys[3];
    logic [35:0] total;
    logic [35:0] w;
    r = 32'(pos.row) % GRID;
    c = 32'(pos.col) % GRID;
    // neighbors off the map wrap around the torus; hash coordinates are one-based
    xs[0] = (r + GRID - 1) % GRID + 1;
    xs[1] = r + 1;
    xs[2] = (r + 1) % GRID + 1;
    ys[0] = (c + GRID - 1) % GRID + 1;
    ys[1] = c + 1;
    ys[2] = (c + 1) % GRID + 1;
    total = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        // center 4, sides 2, corners 1
        if (i == 1 && j == 1) w = 36'd4;
        else if (i == 1 || j == 1) w = 36'd2;
        else w = 36'd1;
        total = total + w * lattice_level(xs[i], ys[j], sd);
      end
    end
    return total;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, limit and reporting
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop: far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("timeout with %0d levels still expected", expected_levels.size());
    $display("status: fail");
    $finish;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input logic [svn_pkg::OUT_W-1:0] want,
                                 input logic [svn_pkg::OUT_W-1:0] got);
    $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready with random gaps, long holds on request, and the checker.
  // ---------------------------------------------------------------------------
  int hold_left;
  int stalls_served;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready  <= 1'b0;
      hold_left     = 0;
      stalls_served = 0;
    end else begin
      // start a long hold when the stimulus asks for one
      if (stalls_served < stall_requests && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        stalls_served++;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each accepted level with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_levels.size() == 0) begin
        report_mismatch("unexpected item", '0, out_ch.smoothed_value);
      end else begin
        if (out_ch.smoothed_value !== expected_levels[0])
          report_mismatch("smoothed_value", expected_levels[0], out_ch.smoothed_value);
        void'(expected_levels.pop_front());
        levels_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers: all of them start and end on a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one position, hold it until accepted, then record the expected level.
  task automatic offer_position(input position_t pos);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.row   <= pos.row;
    in_ch.col   <= pos.col;
    do @(posedge clk); while (!in_ch.ready);
    expected_levels.push_back(smoothed_level(pos, seed_now));
    items_sent++;
  endtask

  // Drop valid and wait until every expected level has arrived, then let the
  // pipeline settle before anything touches the seed.
  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (svn_pkg::PIPE_DEPTH + 3) @(posedge clk);
  endtask

  // APB write of the seed: setup cycle, then access until pready.
  task automatic write_seed(input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= SEED_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    seed_now    = value;
    seeds_used++;
  endtask

  // Random position: mostly anywhere on the map, often on its border rows/columns.
  function automatic position_t random_position();
    position_t pos;
    logic [5:0] border[4];
    border = '{6'd0, 6'd1, 6'd62, 6'd63};
    pos.row = svn_pkg::ROW_W'($urandom_range(GRID - 1));
    pos.col = svn_pkg::COL_W'($urandom_range(GRID - 1));
    case ($urandom_range(9))
      0: pos.row = border[$urandom_range(3)];
      1: pos.col = border[$urandom_range(3)];
      2: begin
        pos.row = border[$urandom_range(3)];
        pos.col = border[$urandom_range(3)];
      end
      default: ;
    endcase
    return pos;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed positions. The hash output cannot be read off by hand, so every
  // row is checked against the predictor; the rows hit the map corners and
  // edges (wrap in each direction), both diagonals and a few interior spots.
  // ---------------------------------------------------------------------------
  localparam int N_DIRECTED = 20;
  localparam position_t DIRECTED[N_DIRECTED] = '{
    '{6'd0,  6'd0 },  '{6'd0,  6'd63},  '{6'd63, 6'd0 },  '{6'd63, 6'd63},
    '{6'd0,  6'd1 },  '{6'd1,  6'd0 },  '{6'd62, 6'd63},  '{6'd63, 6'd62},
    '{6'd1,  6'd1 },  '{6'd62, 6'd62},  '{6'd63, 6'd1 },  '{6'd1,  6'd63},
    '{6'd31, 6'd32},  '{6'd32, 6'd31},  '{6'd21, 6'd42},  '{6'd42, 6'd21},
    '{6'd7,  6'd56},  '{6'd56, 6'd7 },  '{6'd0,  6'd32},  '{6'd32, 6'd0 }
  };

  // Seed settings for the random phases: small, all ones, both signed
  // extremes, back to zero, then free random words.
  logic [31:0] phase_seeds[8];

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.row      <= '0;
    in_ch.col      <= '0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    steady         <= 1'b0;
    stall_requests <= 0;
    seed_now       = 32'd0;
    mismatches     = 0;
    items_sent     = 0;
    levels_checked = 0;
    seeds_used     = 0;

    phase_seeds = '{32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                    32'h0000_0000, $urandom, $urandom, $urandom};

    // hold reset, release on an edge
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass under the reset seed
    for (int k = 0; k < N_DIRECTED; k++) offer_position(DIRECTED[k]);
    drain_pipeline();

    for (int p = 0; p < 8; p++) begin
      write_seed(phase_seeds[p]);
      // phase 2 runs flat out on both sides, broken only by two long holds
      steady <= (p == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && (k == 40 || k == 150)) stall_requests <= stall_requests + 1;
        // phase 4 stops halfway and waits for every level to come back
        if (p == 4 && k == PHASE_ITEMS / 2) drain_pipeline();
        offer_position(random_position());
      end
      drain_pipeline();
      steady <= 1'b0;
    end

    $display("sent %0d positions under %0d written seeds plus the reset seed",
             items_sent, seeds_used);
    $display("checked %0d smoothed levels, %0d mismatches", levels_checked, mismatches);
    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
